// File: src/bdd_pkg.sv
// Package for the binary to decimal digit converter.
// Holds the sizes, the controller state type and the cell control struct.
// No dependencies.
package bdd_pkg;

  localparam int VALUE_BITS = 63;
  // Enough decimal digits for any value below 2**VALUE_BITS.
  localparam int DIGITS     = 19;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W  = $clog2(DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } bdd_state_t;

  // Per-cycle command shared by every cell of the digit chain.
  typedef struct packed {
    logic clear;
    logic convert;
    logic emit;
  } bdd_ctrl_t;

endpackage

// File: src/bdd_if.sv
// Channel interfaces for the binary to decimal digit converter.
// Depends on bdd_pkg for the field widths.
interface bdd_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdd_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface bdd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdd_pkg::CHAR_W-1:0] digit_char;
  logic                       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: src/binary_to_decimal_digits.sv
// Top level of the binary to decimal digit converter.
// Depends on bdd_pkg, bdd_in_if, bdd_out_if and bdd_cell.
//
// Usage: a value arrives on the item channel (valid/ready, transfer when
// both are high). The value is shifted, most significant bit first, into
// a chain of DIGITS BCD cells, one bit per cycle. The chain then shifts
// toward its top cell one digit per cycle while the receiver does not
// stall; leading zeros are dropped silently and every other digit goes
// out on the digits channel, most significant first, with last_digit
// set on the final one. Zero gives the single digit '0'. A new item is
// taken as soon as the last digit sits in the output register, even
// while that register waits. When the receiver stalls, the drain of the
// chain pauses and the held digit stays stable. Reset (rst, synchronous)
// returns the controller to idle and empties the output register; the
// cells need no reset.
module binary_to_decimal_digits (
  input logic       clk,
  input logic       rst,
  bdd_in_if.sink    item,
  bdd_out_if.source digits
);
  import bdd_pkg::*;

  bdd_state_t state, state_next;
  bdd_ctrl_t  ctrl;

  logic [VALUE_BITS-1:0] shreg;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [DIG_CNT_W-1:0]  dig_left;
  logic                  leading;

  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  logic [DIGITS:0] carry;
  logic [3:0]      digit [DIGITS];
  logic [3:0]      lower [DIGITS];
  logic [3:0]      top;

  logic accept;
  logic out_free;
  logic emit_step;
  logic emit_show;

  assign carry[0] = shreg[VALUE_BITS-1];
  assign top      = digit[DIGITS-1];

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lower[i] = 4'd0;
    end else begin : g_rest
      assign lower[i] = digit[i-1];
    end
    bdd_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .carry_in    (carry[i]),
      .lower_digit (lower[i]),
      .carry_out   (carry[i+1]),
      .digit       (digit[i])
    );
  end

  assign accept    = (state == ST_IDLE) && item.valid;
  assign out_free  = !out_valid || digits.ready;
  assign emit_step = (state == ST_EMIT) && out_free;
  // A zero at the top is shown unless it is still a leading zero, and the
  // final digit is always shown so that zero yields '0'.
  assign emit_show = emit_step &&
                     (!leading || (top != 4'd0) || (dig_left == DIG_CNT_W'(1)));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item.valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt == '0) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_step && (dig_left == DIG_CNT_W'(1))) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready   = (state == ST_IDLE);
    ctrl.clear   = accept;
    ctrl.convert = (state == ST_CONVERT);
    ctrl.emit    = emit_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_show) begin
        out_valid <= 1'b1;
      end else if (digits.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg    <= item.value;
      bit_cnt  <= BIT_CNT_W'(VALUE_BITS - 1);
      dig_left <= DIG_CNT_W'(DIGITS);
      leading  <= 1'b1;
    end else if (state == ST_CONVERT) begin
      shreg   <= {shreg[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end else if (emit_step) begin
      dig_left <= dig_left - DIG_CNT_W'(1);
      if (emit_show) leading <= 1'b0;
    end
    if (emit_show) begin
      out_char <= ASCII_ZERO + {2'b00, top};
      out_last <= (dig_left == DIG_CNT_W'(1));
    end
  end

  assign digits.valid      = out_valid;
  assign digits.digit_char = out_char;
  assign digits.last_digit = out_last;

endmodule

// File: src/bdd_cell.sv
// One BCD digit cell of the double dabble chain.
// Depends on bdd_pkg for the control struct.
module bdd_cell (
  input  logic              clk,
  input  bdd_pkg::bdd_ctrl_t ctrl,
  input  logic              carry_in,
  input  logic [3:0]        lower_digit,
  output logic              carry_out,
  output logic [3:0]        digit
);
  import bdd_pkg::*;

  logic [3:0] adjusted;
  logic [3:0] digit_next;

  // Add three before the shift so that the doubled digit carries at ten.
  always_comb begin
    adjusted  = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adjusted[3];
  end

  always_comb begin
    if (ctrl.clear) begin
      digit_next = 4'd0;
    end else if (ctrl.convert) begin
      digit_next = {adjusted[2:0], carry_in};
    end else if (ctrl.emit) begin
      digit_next = lower_digit;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule
